// ===== hdl/iso2ep_pkg.sv =====
// iso2ep_pkg: shared types, constants and the microcode store of the timestamp converter
// used by every module under hdl; depends on nothing

package iso2ep_pkg;

    localparam int TS_LEN  = 19;
    localparam int POS_W   = 5;
    localparam int YEAR_W  = 14;
    localparam int FIELD_W = 7;
    localparam int EPOCH_W = 39;
    localparam int STEP_W  = 4;

    // character positions of the fixed layout
    localparam logic [POS_W-1:0] POS_DASH1  = 5'd4;
    localparam logic [POS_W-1:0] POS_DASH2  = 5'd7;
    localparam logic [POS_W-1:0] POS_T      = 5'd10;
    localparam logic [POS_W-1:0] POS_COLON1 = 5'd13;
    localparam logic [POS_W-1:0] POS_COLON2 = 5'd16;
    localparam logic [POS_W-1:0] POS_MONTH  = 5'd5;
    localparam logic [POS_W-1:0] POS_DAY    = 5'd8;
    localparam logic [POS_W-1:0] POS_HOUR   = 5'd11;
    localparam logic [POS_W-1:0] POS_MINUTE = 5'd14;
    localparam logic [POS_W-1:0] POS_END    = 5'd19;

    localparam logic [7:0] CHAR_DASH = 8'h2D;
    localparam logic [7:0] CHAR_T    = 8'h54;
    localparam logic [7:0] CHAR_0    = 8'h30;
    localparam logic [7:0] CHAR_9    = 8'h39;

    localparam logic [16:0] SEC_PER_DAY   = 17'd86400;
    localparam logic [11:0] SEC_PER_HOUR  = 12'd3600;
    localparam logic [5:0]  SEC_PER_MIN   = 6'd60;
    localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
    // 719468 days from 0000-03-01 to 1970-01-01, plus one for the day-of-month bias
    localparam logic [19:0] EPOCH_OFS     = 20'd719469;
    // floor(y / 100) == (y * 5243) >> 19 for every 14-bit y
    localparam logic [12:0] RECIP_100     = 13'd5243;
    localparam int          RECIP_SHIFT   = 19;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_CLR,
        OP_ADD,
        OP_SUB,
        OP_MUL
    } acc_op_t;

    typedef enum logic [3:0] {
        SRC_Y365,
        SRC_Y4,
        SRC_Q,
        SRC_Q4,
        SRC_DOY,
        SRC_OFS,
        SRC_HOUR,
        SRC_MINUTE,
        SRC_SECOND
    } src_t;

    typedef struct packed {
        acc_op_t op;
        src_t    src;
        logic    ld_y;
        logic    ld_q;
        logic    br_fail;
        logic    last;
    } uop_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [FIELD_W-1:0] month;
        logic [FIELD_W-1:0] day;
        logic [FIELD_W-1:0] hour;
        logic [FIELD_W-1:0] minute;
        logic [FIELD_W-1:0] second;
        logic               ok;
    } fields_t;

    localparam logic [STEP_W-1:0] STEP_FIRST = 4'd0;
    localparam logic [STEP_W-1:0] STEP_EMIT  = 4'd11;

    // days-from-civil program: one accumulator, one control word per step
    function automatic uop_t ucode(input logic [STEP_W-1:0] step);
        uop_t u;
        u = '{op: OP_NOP, src: SRC_Y365, ld_y: 1'b0, ld_q: 1'b0, br_fail: 1'b0, last: 1'b0};
        unique case (step)
            4'd0:
            begin
                u.op      = OP_CLR;
                u.ld_y    = 1'b1;
                u.br_fail = 1'b1;
            end
            4'd1:
            begin
                u.op   = OP_ADD;
                u.src  = SRC_Y365;
                u.ld_q = 1'b1;
            end
            4'd2:  begin u.op = OP_ADD; u.src = SRC_Y4;     end
            4'd3:  begin u.op = OP_SUB; u.src = SRC_Q;      end
            4'd4:  begin u.op = OP_ADD; u.src = SRC_Q4;     end
            4'd5:  begin u.op = OP_ADD; u.src = SRC_DOY;    end
            4'd6:  begin u.op = OP_SUB; u.src = SRC_OFS;    end
            4'd7:  begin u.op = OP_MUL;                     end
            4'd8:  begin u.op = OP_ADD; u.src = SRC_HOUR;   end
            4'd9:  begin u.op = OP_ADD; u.src = SRC_MINUTE; end
            4'd10: begin u.op = OP_ADD; u.src = SRC_SECOND; end
            default:
            begin
                u.last = 1'b1;
            end
        endcase
        return u;
    endfunction

    // days before the first of each month, counted from March
    function automatic logic [8:0] doy_of(input logic [3:0] mp);
        logic [8:0] d;
        unique case (mp)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== hdl/iso8601_timestamp_to_epoch_unit.sv =====
// Timestamp converter: takes a YYYY-MM-DDTHH:MM:SS text one character per item on the input
// channel, with is_final on the last character, and returns one result per text: Unix seconds
// and valid_res, or zero with valid_res low when the layout, the digits or a range check fails
// or fewer than nineteen characters arrived. Characters past the nineteenth are ignored.
// Characters are taken one per cycle. After the final character the input stalls while a
// twelve-step microcode program runs the days-from-civil arithmetic on a single accumulator
// (two steps for a rejected text); the program also waits on its last step while an earlier
// result sits unclaimed in the output register.
// Built from iso2ep_pkg, iso2ep_parser, iso2ep_seq and iso2ep_alu.

module iso8601_timestamp_to_epoch_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [7:0]                             text_char,
    input  logic                                   is_final,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [iso2ep_pkg::EPOCH_W-1:0]  epoch_seconds,
    output logic                                   valid_res
);
    import iso2ep_pkg::*;

    fields_t                   fields;
    uop_t                      uop;
    logic                      busy;
    logic                      accept;
    logic                      start;
    logic                      emit_ok;
    logic                      emit;
    logic signed [EPOCH_W-1:0] acc;
    logic                      out_valid_reg, out_valid_next;
    logic signed [EPOCH_W-1:0] epoch_reg;
    logic                      valid_res_reg;

    assign in_ready = !busy;
    assign accept   = in_valid && in_ready;
    assign start    = accept && is_final;
    assign emit_ok  = !out_valid_reg || out_ready;
    assign emit     = busy && uop.last && emit_ok;

    iso2ep_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .text_char (text_char),
        .clear     (emit),
        .fields    (fields)
    );

    iso2ep_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .cond_ok (fields.ok),
        .emit_ok (emit_ok),
        .uop     (uop),
        .busy    (busy)
    );

    iso2ep_alu u_alu (
        .clk    (clk),
        .en     (busy),
        .uop    (uop),
        .fields (fields),
        .acc    (acc)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            epoch_reg     <= acc;
            valid_res_reg <= fields.ok;
        end
    end

    assign out_valid     = out_valid_reg;
    assign epoch_seconds = epoch_reg;
    assign valid_res     = valid_res_reg;

    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy)
        else $error("final character did not start the program");

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid_reg)
        else $error("result lost at the output register");

    a_epoch_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && valid_res_reg |->
            (epoch_reg >= -39'sd62135596800) && (epoch_reg <= 39'sd253402300800))
        else $error("accepted timestamp converted out of range");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !valid_res_reg |-> epoch_reg == '0)
        else $error("rejected text gave a nonzero result");

endmodule

// ===== hdl/iso2ep_parser.sv =====
// iso2ep_parser: character intake, separator and digit checks, field accumulation
// depends on iso2ep_pkg

module iso2ep_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          text_char,
    input  logic                clear,
    output iso2ep_pkg::fields_t fields
);
    import iso2ep_pkg::*;

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [YEAR_W-1:0]  year_reg, year_next;
    logic [FIELD_W-1:0] month_reg, month_next;
    logic [FIELD_W-1:0] day_reg, day_next;
    logic [FIELD_W-1:0] hour_reg, hour_next;
    logic [FIELD_W-1:0] minute_reg, minute_next;
    logic [FIELD_W-1:0] second_reg, second_next;
    logic               fault_reg, fault_next;
    logic               digit;
    logic [7:0]         digit_off;
    logic [3:0]         d;

    assign digit     = (text_char >= CHAR_0) && (text_char <= CHAR_9);
    assign digit_off = text_char - CHAR_0;
    assign d         = digit_off[3:0];

    always_comb
    begin
        pos_next    = pos_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        fault_next  = fault_reg;
        if (clear)
        begin
            pos_next    = '0;
            year_next   = '0;
            month_next  = '0;
            day_next    = '0;
            hour_next   = '0;
            minute_next = '0;
            second_next = '0;
            fault_next  = 1'b0;
        end
        else if (accept && (pos_reg < POS_END))
        begin
            pos_next = pos_reg + 5'd1;
            priority if ((pos_reg == POS_DASH1) || (pos_reg == POS_DASH2))
            begin
                if (text_char != CHAR_DASH)
                    fault_next = 1'b1;
            end
            else if (pos_reg == POS_T)
            begin
                if (text_char != CHAR_T)
                    fault_next = 1'b1;
            end
            else if ((pos_reg == POS_COLON1) || (pos_reg == POS_COLON2))
            begin
                // colons are not checked
            end
            else if (!digit)
            begin
                fault_next = 1'b1;
            end
            else if (pos_reg < POS_MONTH)
            begin
                year_next = (year_reg << 3) + (year_reg << 1) + YEAR_W'(d);
            end
            else if (pos_reg < POS_DAY)
            begin
                month_next = (month_reg << 3) + (month_reg << 1) + FIELD_W'(d);
            end
            else if (pos_reg < POS_HOUR)
            begin
                day_next = (day_reg << 3) + (day_reg << 1) + FIELD_W'(d);
            end
            else if (pos_reg < POS_COLON1)
            begin
                hour_next = (hour_reg << 3) + (hour_reg << 1) + FIELD_W'(d);
            end
            else if (pos_reg < POS_COLON2)
            begin
                minute_next = (minute_reg << 3) + (minute_reg << 1) + FIELD_W'(d);
            end
            else
            begin
                second_next = (second_reg << 3) + (second_reg << 1) + FIELD_W'(d);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            year_reg   <= '0;
            month_reg  <= '0;
            day_reg    <= '0;
            hour_reg   <= '0;
            minute_reg <= '0;
            second_reg <= '0;
            fault_reg  <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            year_reg   <= year_next;
            month_reg  <= month_next;
            day_reg    <= day_next;
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
            fault_reg  <= fault_next;
        end
    end

    always_comb
    begin
        fields.year   = year_reg;
        fields.month  = month_reg;
        fields.day    = day_reg;
        fields.hour   = hour_reg;
        fields.minute = minute_reg;
        fields.second = second_reg;
        fields.ok     = (pos_reg == POS_END) && !fault_reg && (year_reg != '0) &&
                        (month_reg >= 7'd1) && (month_reg <= 7'd12) &&
                        (day_reg >= 7'd1) && (day_reg <= 7'd31) &&
                        (hour_reg <= 7'd23) && (minute_reg <= 7'd59) &&
                        (second_reg <= 7'd60);
    end

    a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg == POS_END && !clear |=> pos_reg == POS_END)
        else $error("character position left saturation without a clear");

endmodule

// ===== hdl/iso2ep_seq.sv =====
// iso2ep_seq: step counter and microcode fetch with the fail branch
// depends on iso2ep_pkg

module iso2ep_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             cond_ok,
    input  logic             emit_ok,
    output iso2ep_pkg::uop_t uop,
    output logic             busy
);
    import iso2ep_pkg::*;

    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;

    assign uop  = ucode(step_reg);
    assign busy = busy_reg;

    always_comb
    begin
        step_next = step_reg;
        busy_next = busy_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                step_next = STEP_FIRST;
            end
        end
        else if (uop.last)
        begin
            // hold on the emit step until the output register is free
            if (emit_ok)
            begin
                busy_next = 1'b0;
                step_next = STEP_FIRST;
            end
        end
        else if (uop.br_fail && !cond_ok)
        begin
            step_next = STEP_EMIT;
        end
        else
        begin
            step_next = step_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_FIRST;
            busy_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
        end
    end

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> step_reg <= STEP_EMIT)
        else $error("step counter ran past the program");

    a_no_early_exit: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !uop.last |=> busy_reg)
        else $error("sequencer stopped before the emit step");

endmodule

// ===== hdl/iso2ep_alu.sv =====
// iso2ep_alu: accumulator datapath for the date arithmetic, driven by microcode
// depends on iso2ep_pkg

module iso2ep_alu (
    input  logic                       clk,
    input  logic                       en,
    input  iso2ep_pkg::uop_t           uop,
    input  iso2ep_pkg::fields_t        fields,
    output logic signed [iso2ep_pkg::EPOCH_W-1:0] acc
);
    import iso2ep_pkg::*;

    logic [YEAR_W-1:0]         yp_reg, yp_next;
    logic [7:0]                q_reg, q_next;
    logic signed [EPOCH_W-1:0] acc_reg, acc_next;
    logic signed [EPOCH_W-1:0] opnd;
    logic                      early_month;
    logic [FIELD_W-1:0]        mp_wide;
    logic [22:0]               y365;
    logic [26:0]               qprod;
    logic [18:0]               hour_s;
    logic [12:0]               minute_s;
    logic [9:0]                doy_d;
    logic signed [41:0]        day_mul;

    // january and february count as months of the previous year
    assign early_month = fields.month <= 7'd2;
    assign mp_wide     = early_month ? fields.month + 7'd9 : fields.month - 7'd3;

    assign y365     = yp_reg * DAYS_PER_YEAR;
    assign qprod    = yp_reg * RECIP_100;
    assign hour_s   = fields.hour * SEC_PER_HOUR;
    assign minute_s = fields.minute * SEC_PER_MIN;
    assign doy_d    = 10'(doy_of(mp_wide[3:0])) + 10'(fields.day);
    assign day_mul  = $signed(acc_reg[23:0]) * $signed({1'b0, SEC_PER_DAY});

    always_comb
    begin
        unique case (uop.src)
            SRC_Y365:   opnd = $signed(EPOCH_W'(y365));
            SRC_Y4:     opnd = $signed(EPOCH_W'(yp_reg >> 2));
            SRC_Q:      opnd = $signed(EPOCH_W'(q_reg));
            SRC_Q4:     opnd = $signed(EPOCH_W'(q_reg >> 2));
            SRC_DOY:    opnd = $signed(EPOCH_W'(doy_d));
            SRC_OFS:    opnd = $signed(EPOCH_W'(EPOCH_OFS));
            SRC_HOUR:   opnd = $signed(EPOCH_W'(hour_s));
            SRC_MINUTE: opnd = $signed(EPOCH_W'(minute_s));
            SRC_SECOND: opnd = $signed(EPOCH_W'(fields.second));
            default:    opnd = '0;
        endcase
    end

    always_comb
    begin
        yp_next  = yp_reg;
        q_next   = q_reg;
        acc_next = acc_reg;
        if (en)
        begin
            if (uop.ld_y)
                yp_next = fields.year - YEAR_W'(early_month);
            if (uop.ld_q)
                q_next = qprod[26:RECIP_SHIFT];
            unique case (uop.op)
                OP_NOP:  acc_next = acc_reg;
                OP_CLR:  acc_next = '0;
                OP_ADD:  acc_next = acc_reg + opnd;
                OP_SUB:  acc_next = acc_reg - opnd;
                OP_MUL:  acc_next = day_mul[EPOCH_W-1:0];
                default: acc_next = acc_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        yp_reg  <= yp_next;
        q_reg   <= q_next;
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule
